// ----- hw/rtl/fermat_factor_step_defines.svh -----
// assertion macros for the fermat factor block
`ifndef FERMAT_FACTOR_STEP_DEFINES_SVH
`define FERMAT_FACTOR_STEP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define FFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/ffs_pkg.sv -----
`timescale 1ns / 1ps
package ffs_pkg;

    localparam int DEF_NUM_BITS = 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROOT,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic done;
        logic exact;
    } t_sqrt_sts;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_sts;

endpackage

// ----- hw/rtl/ffs_isqrt.sv -----
`timescale 1ns / 1ps
module ffs_isqrt import ffs_pkg::*; #(
    parameter int NUM_BITS = DEF_NUM_BITS,
    localparam int HALF = (NUM_BITS + 1) / 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_value,
    output t_sqrt_sts           o_sts,
    output logic [HALF-1:0]     o_root
);

    localparam int OPW   = 2 * HALF;
    localparam int REMW  = HALF + 2;
    localparam int CATW  = HALF + 4;
    localparam int CNT_W = $clog2(HALF + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [OPW-1:0]    r_op;
    logic [REMW-1:0]   r_rem;
    logic [HALF-1:0]   r_root;

    logic [CATW-1:0]   cat;
    logic [CATW-1:0]   trial;
    logic              take;

    // one result bit per step, two operand bits brought down each time
    assign cat   = {r_rem, r_op[OPW-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign take  = (cat >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(HALF);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op   <= OPW'(i_value);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_op <= {r_op[OPW-3:0], 2'b00};
            if (take) begin
                r_rem  <= REMW'(cat - trial);
                r_root <= {r_root[HALF-2:0], 1'b1};
            end else begin
                r_rem  <= REMW'(cat);
                r_root <= {r_root[HALF-2:0], 1'b0};
            end
        end
    end

    assign o_sts.done  = r_busy && (r_cnt == '0);
    assign o_sts.exact = (r_rem == '0);
    assign o_root      = r_root;

endmodule

// ----- hw/rtl/ffs_div.sv -----
`timescale 1ns / 1ps
module ffs_div import ffs_pkg::*; #(
    parameter int NUM_BITS = DEF_NUM_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_dividend,
    input  logic [NUM_BITS-1:0] i_divisor,
    output t_div_sts            o_sts,
    output logic [NUM_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_BITS-1:0] r_quo;
    logic [NUM_BITS-1:0] r_rem;
    logic [NUM_BITS-1:0] r_dvs;

    logic [NUM_BITS:0]   part;
    logic [NUM_BITS:0]   diff;
    logic                fits;

    // restoring division, one quotient bit per step
    assign part = {r_rem, r_quo[NUM_BITS-1]};
    assign diff = part - {1'b0, r_dvs};
    assign fits = (part >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_BITS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_quo <= {r_quo[NUM_BITS-2:0], fits};
            r_rem <= fits ? diff[NUM_BITS-1:0] : part[NUM_BITS-1:0];
        end
    end

    assign o_sts.done     = r_busy && (r_cnt == '0);
    assign o_sts.rem_zero = (r_rem == '0);
    assign o_quotient     = r_quo;

endmodule

// ----- hw/rtl/fermat_factor_step.sv -----
`timescale 1ns / 1ps
// Splits a positive integer into one factor pair by Fermat's method.
// Command channel: a word on i_number is taken at a clock edge where start is
// high and busy is low. busy stays high until the result has been shown.
// Result channel: o_found, o_factor_large and o_factor_small are valid for
// exactly one cycle while o_valid is high; the receiver cannot stall them.
// A perfect square returns its root twice; otherwise the largest divisor a of
// the number, 2 <= a <= floor(sqrt), with n/a of the same parity gives
// o_factor_small = a and o_factor_large = n/a. No such divisor, or a zero
// input, gives o_found = 0 and zero factors.
// Sequence: one integer square root, then one restoring division per trial
// divisor, counting down from floor(sqrt(n)) to 2, at most floor(sqrt(n)) - 1
// trials; a zero input goes straight to the result. After the result the
// sequencer is idle again and can take the next word. The division unit sets
// the pace. One word is in flight at a time.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_valid; a word in flight is lost.
`include "fermat_factor_step_defines.svh"
module fermat_factor_step import ffs_pkg::*; #(
    parameter int NUM_BITS = DEF_NUM_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [NUM_BITS-1:0] i_number,
    output logic                o_valid,
    output logic                o_found,
    output logic [NUM_BITS-1:0] o_factor_large,
    output logic [NUM_BITS-1:0] o_factor_small
);

    localparam int HALF = (NUM_BITS + 1) / 2;

    t_state              r_state;
    t_state              n_state;

    logic [NUM_BITS-1:0] r_number;
    logic [HALF-1:0]     r_a;
    logic                r_found;
    logic [NUM_BITS-1:0] r_big;
    logic [NUM_BITS-1:0] r_small;

    t_sqrt_sts           sqrt_sts;
    t_div_sts            div_sts;
    logic [HALF-1:0]     root;
    logic [NUM_BITS-1:0] quotient;

    logic                accept;
    logic                sqrt_start;
    logic                div_start;
    logic                root_small;
    logic                hit;
    logic                last_a;
    logic [HALF-1:0]     next_a;
    logic [NUM_BITS-1:0] divisor;

    assign accept     = start && (r_state == S_IDLE);
    assign root_small = (root[HALF-1:1] == '0);
    assign hit        = div_sts.rem_zero && (r_a[0] == quotient[0]);
    assign last_a     = (r_a[HALF-1:1] == '0) || (r_a == HALF'(2));
    assign next_a     = r_a - 1'b1;
    assign divisor    = (r_state == S_ROOT) ? NUM_BITS'(root) : NUM_BITS'(next_a);

    ffs_isqrt #(.NUM_BITS(NUM_BITS)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (i_number),
        .o_sts   (sqrt_sts),
        .o_root  (root)
    );

    ffs_div #(.NUM_BITS(NUM_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_number),
        .i_divisor  (divisor),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_number == '0) ? S_DONE : S_ROOT;
                end
            end
            S_ROOT: begin
                if (sqrt_sts.done) begin
                    n_state = (sqrt_sts.exact || root_small) ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                if (div_sts.done && (hit || last_a)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        busy       = 1'b1;
        o_valid    = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                sqrt_start = start && (i_number != '0);
            end
            S_ROOT: div_start = sqrt_sts.done && !sqrt_sts.exact && !root_small;
            S_DIV:  div_start = div_sts.done && !hit && !last_a;
            S_DONE: o_valid = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_number <= i_number;
            r_found  <= 1'b0;
            r_big    <= '0;
            r_small  <= '0;
        end else if ((r_state == S_ROOT) && sqrt_sts.done) begin
            r_a <= root;
            if (sqrt_sts.exact) begin
                r_found <= 1'b1;
                r_big   <= NUM_BITS'(root);
                r_small <= NUM_BITS'(root);
            end
        end else if ((r_state == S_DIV) && div_sts.done) begin
            if (hit) begin
                r_found <= 1'b1;
                r_big   <= quotient;
                r_small <= NUM_BITS'(r_a);
            end else begin
                r_a <= next_a;
            end
        end
    end

    assign o_found        = r_found;
    assign o_factor_large = r_big;
    assign o_factor_small = r_small;

    `FFS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy did not rise on accept")
    `FFS_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result strobe longer than one cycle")
    `FFS_ASSERT_SAME(a_found_nonzero, i_clk, i_rst_n, o_valid && o_found, o_factor_small != '0, "found with zero factor")
    `FFS_ASSERT_SAME(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found, (o_factor_large == '0) && (o_factor_small == '0), "miss with nonzero factors")

endmodule
